// File: hw/rtl/campose_pkg.sv
// campose_pkg: types, constants and tables shared by the camera pose update block
// used by the channel interfaces, campose_ctrl, campose_dp and camera_pose_update
`timescale 1ns / 1ps
`default_nettype none

package campose_pkg;

	// coordinate and field widths
	localparam int COORD_W    = 32;            // stored coordinate width
	localparam int FRAC_BITS  = 16;            // fraction bits of coordinates and amount
	localparam int AMT_W      = 32;            // amount field width
	localparam int OUT_W      = 32;            // result coordinate field width
	localparam int OP_W       = 3;             // command code width
	localparam int OFF_W      = COORD_W + 1;   // clamped offset width
	localparam int OPND_W     = COORD_W + 2;   // multiplier operand width
	localparam int PROD_W     = 2 * OPND_W;    // product and accumulator width
	localparam int XY_W       = 34;            // cordic x and y, Q2.30 with headroom
	localparam int Z_W        = 36;            // cordic residual angle, Q32
	localparam int REM_W      = 33;            // angle reduction remainder
	localparam int ANG_W      = 20;            // reduced angle in Q16, signed
	localparam int IDX_W      = 5;             // step index carried to the datapath
	localparam int ROT_SHIFT  = 30;            // cos and sin are Q2.30

	// apb
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// angle constants
	localparam logic [REM_W-1:0]      TWO_PI_Q16  = 33'd411775;
	localparam logic [REM_W-1:0]      PI_Q16      = 33'd205887;
	// multiple of two pi above 2^31, keeps the biased angle non-negative
	localparam logic [REM_W-1:0]      MOD_BIAS    = 33'd2147818400;
	localparam logic signed [Z_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
	localparam logic signed [Z_W-1:0] PI_Q32      = 36'sd13493037705;
	localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032875;

	// angle reduction: 14 quotient bits, two per cycle
	localparam int          MOD_PAIRS  = 7;
	localparam logic [3:0]  MOD_K_LO0  = 4'd12;

	// product phase lengths (last phase index)
	localparam int PROD_LAST_ROT  = 5;
	localparam int PROD_LAST_MOVE = 3;

	localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
	localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t look_x;
		coord_t look_y;
		coord_t look_z;
	} pose_t;

	localparam pose_t POSE_RESET = '{
		pos_x:  32'sd0,
		pos_y:  32'sd0,
		pos_z:  32'sd0,
		look_x: 32'sd0,
		look_y: 32'sd0,
		look_z: -32'sd65536
	};

	typedef enum logic [OP_W-1:0] {
		OP_RELOAD   = 3'd0,
		OP_FORWARD  = 3'd1,
		OP_STRAFE   = 3'd2,
		OP_VERTICAL = 3'd3,
		OP_ROTATE   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_START_POS_X  = 3'd0,
		REG_START_POS_Y  = 3'd1,
		REG_START_POS_Z  = 3'd2,
		REG_START_VIEW_X = 3'd3,
		REG_START_VIEW_Y = 3'd4,
		REG_START_VIEW_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_FOLD,
		ST_ROT,
		ST_PROD,
		ST_APPLY
	} ctrl_state_t;

	typedef enum logic [2:0] {
		MS_DIRX_AMT,
		MS_DIRZ_AMT,
		MS_CS_DX,
		MS_SN_DZ,
		MS_SN_DX,
		MS_CS_DZ
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic             load;
		logic             mod_step;
		logic             fold;
		logic             rot_step;
		logic [IDX_W-1:0] idx;
		logic             mul_en;
		mul_sel_t         mul_sel;
		acc_op_t          acc_op;
		logic             take_ox;
		logic             take_oz;
		logic             apply;
	} dp_cmd_t;

	typedef struct packed {
		op_t op;
	} dp_stat_t;

	// atan(2^-i) in Q32, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q32(input logic [IDX_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:    v = 36'sd3373259426;
			5'd1:    v = 36'sd1991351318;
			5'd2:    v = 36'sd1052175346;
			5'd3:    v = 36'sd534100635;
			5'd4:    v = 36'sd268086748;
			5'd5:    v = 36'sd134174063;
			5'd6:    v = 36'sd67103403;
			5'd7:    v = 36'sd33553749;
			5'd8:    v = 36'sd16777131;
			5'd9:    v = 36'sd8388597;
			5'd10:   v = 36'sd4194303;
			5'd11:   v = 36'sd2097152;
			5'd12:   v = 36'sd1048576;
			5'd13:   v = 36'sd524288;
			5'd14:   v = 36'sd262144;
			5'd15:   v = 36'sd131072;
			5'd16:   v = 36'sd65536;
			5'd17:   v = 36'sd32768;
			5'd18:   v = 36'sd16384;
			5'd19:   v = 36'sd8192;
			5'd20:   v = 36'sd4096;
			5'd21:   v = 36'sd2048;
			5'd22:   v = 36'sd1024;
			5'd23:   v = 36'sd512;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/campose_if.sv
// campose_if: valid/ready channels for command beats and pose beats
// depends on campose_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface campose_cmd_if;
	import campose_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         cmd;
	logic signed [AMT_W-1:0] amount;

	modport source (output valid, cmd, amount, input ready);
	modport sink   (input valid, cmd, amount, output ready);
endinterface

interface campose_pose_if;
	import campose_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] pos_x;
	logic signed [OUT_W-1:0] pos_y;
	logic signed [OUT_W-1:0] pos_z;
	logic signed [OUT_W-1:0] look_x;
	logic signed [OUT_W-1:0] look_y;
	logic signed [OUT_W-1:0] look_z;
	logic                    saturated;

	modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, saturated,
		input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, saturated,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/campose_dp.sv
// campose_dp: pose registers, angle reduction, cordic rotator, shared multiplier
// depends on campose_pkg; driven by campose_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module campose_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  campose_pkg::dp_cmd_t              dp_cmd,
	output campose_pkg::dp_stat_t             dp_stat,
	input  logic [campose_pkg::OP_W-1:0]      in_cmd,
	input  logic signed [campose_pkg::AMT_W-1:0] in_amount,
	input  campose_pkg::pose_t                cfg_pose,
	output campose_pkg::pose_t                pose,
	output logic                              saturated
);
	import campose_pkg::*;

	// add an offset to a coordinate and saturate; msb of result is the clamp flag
	function automatic logic [COORD_W:0] sat_add(input coord_t c, input logic signed [OFF_W-1:0] o);
		logic signed [OFF_W:0] s;
		logic [COORD_W:0]      r;
		s = (OFF_W+1)'(c) + (OFF_W+1)'(o);
		if ((&s[OFF_W:COORD_W-1]) || !(|s[OFF_W:COORD_W-1])) begin
			r = {1'b0, s[COORD_W-1:0]};
		end else if (s[OFF_W]) begin
			r = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	pose_t                     pose_q;
	logic                      sat_out_q;
	op_t                       op_q;
	logic signed [AMT_W-1:0]   amt_q;
	logic [REM_W-1:0]          rem_q;
	logic signed [XY_W-1:0]    x_q, y_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      flip_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [OFF_W-1:0]   ox_q, oz_q;
	logic                      sat_acc_q;

	// direction vectors
	logic signed [OFF_W-1:0]   dx, dz, dir_x, dir_z;
	logic signed [XY_W-1:0]    cs, sn;
	logic signed [OPND_W-1:0]  mul_a, mul_b;

	assign dx    = OFF_W'(pose_q.look_x) - OFF_W'(pose_q.pos_x);
	assign dz    = OFF_W'(pose_q.look_z) - OFF_W'(pose_q.pos_z);
	assign dir_x = (op_q == OP_STRAFE) ? -dz : dx;
	assign dir_z = (op_q == OP_STRAFE) ? dx : dz;
	assign cs    = flip_q ? -x_q : x_q;
	assign sn    = flip_q ? -y_q : y_q;

	always_comb begin
		case (dp_cmd.mul_sel)
			MS_DIRX_AMT: begin mul_a = OPND_W'(dir_x); mul_b = OPND_W'(amt_q); end
			MS_DIRZ_AMT: begin mul_a = OPND_W'(dir_z); mul_b = OPND_W'(amt_q); end
			MS_CS_DX:    begin mul_a = OPND_W'(cs);    mul_b = OPND_W'(dx);    end
			MS_SN_DZ:    begin mul_a = OPND_W'(sn);    mul_b = OPND_W'(dz);    end
			MS_SN_DX:    begin mul_a = OPND_W'(sn);    mul_b = OPND_W'(dx);    end
			MS_CS_DZ:    begin mul_a = OPND_W'(cs);    mul_b = OPND_W'(dz);    end
			default:     begin mul_a = '0;             mul_b = '0;             end
		endcase
	end

	// two restoring steps of the modulo two pi reduction
	logic [3:0]       k_lo, k_hi;
	logic [REM_W-1:0] tp_hi, tp_lo, rem_1, rem_2;

	assign k_lo  = MOD_K_LO0 - {dp_cmd.idx[2:0], 1'b0};
	assign k_hi  = k_lo + 4'd1;
	assign tp_hi = TWO_PI_Q16 << k_hi;
	assign tp_lo = TWO_PI_Q16 << k_lo;
	assign rem_1 = (rem_q >= tp_hi) ? rem_q - tp_hi : rem_q;
	assign rem_2 = (rem_1 >= tp_lo) ? rem_1 - tp_lo : rem_1;

	// fold into (-pi, pi] then into [-pi/2, pi/2]
	logic signed [ANG_W-1:0] ang;
	logic signed [Z_W-1:0]   z_full, z_fold;
	logic                    flip_d;

	always_comb begin
		if (rem_q > PI_Q16) begin
			ang = ANG_W'(rem_q) - ANG_W'(TWO_PI_Q16);
		end else begin
			ang = ANG_W'(rem_q);
		end
		z_full = Z_W'(ang) <<< FRAC_BITS;
		if (z_full > HALF_PI_Q32) begin
			z_fold = z_full - PI_Q32;
			flip_d = 1'b1;
		end else if (z_full < -HALF_PI_Q32) begin
			z_fold = z_full + PI_Q32;
			flip_d = 1'b1;
		end else begin
			z_fold = z_full;
			flip_d = 1'b0;
		end
	end

	// one cordic micro-rotation
	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0]  atan_i;

	assign xs     = x_q >>> dp_cmd.idx;
	assign ys     = y_q >>> dp_cmd.idx;
	assign atan_i = atan_q32(dp_cmd.idx);

	// shift the accumulator back and clamp to the offset range
	logic signed [PROD_W-1:0] acc_sh;
	logic                     acc_fits;
	logic signed [OFF_W-1:0]  acc_clamp;

	always_comb begin
		acc_sh    = (op_q == OP_ROTATE) ? (acc_q >>> ROT_SHIFT) : (acc_q >>> FRAC_BITS);
		acc_fits  = (&acc_sh[PROD_W-1:OFF_W-1]) || !(|acc_sh[PROD_W-1:OFF_W-1]);
		acc_clamp = acc_fits ? acc_sh[OFF_W-1:0] : (acc_sh[PROD_W-1] ? OFF_MIN : OFF_MAX);
	end

	// pose update
	logic signed [OFF_W-1:0] off_y;
	logic [COORD_W:0]        sa_px, sa_py, sa_pz, sa_lx, sa_ly, sa_lz;
	pose_t                   pose_d;
	logic                    hit_d;

	assign off_y = OFF_W'(amt_q);
	assign sa_px = sat_add(pose_q.pos_x, ox_q);
	assign sa_pz = sat_add(pose_q.pos_z, oz_q);
	assign sa_lx = sat_add(pose_q.look_x, ox_q);
	assign sa_lz = sat_add(pose_q.look_z, oz_q);
	assign sa_py = sat_add(pose_q.pos_y, off_y);
	assign sa_ly = sat_add(pose_q.look_y, off_y);

	always_comb begin
		pose_d = pose_q;
		hit_d  = 1'b0;
		case (op_q)
			OP_RELOAD: begin
				pose_d = cfg_pose;
			end
			OP_FORWARD, OP_STRAFE: begin
				pose_d.pos_x  = sa_px[COORD_W-1:0];
				pose_d.pos_z  = sa_pz[COORD_W-1:0];
				pose_d.look_x = sa_lx[COORD_W-1:0];
				pose_d.look_z = sa_lz[COORD_W-1:0];
				hit_d = sa_px[COORD_W] | sa_pz[COORD_W] | sa_lx[COORD_W] | sa_lz[COORD_W];
			end
			OP_VERTICAL: begin
				pose_d.pos_y  = sa_py[COORD_W-1:0];
				pose_d.look_y = sa_ly[COORD_W-1:0];
				hit_d = sa_py[COORD_W] | sa_ly[COORD_W];
			end
			OP_ROTATE: begin
				// view point swings around the position
				pose_d.look_x = sa_px[COORD_W-1:0];
				pose_d.look_z = sa_pz[COORD_W-1:0];
				hit_d = sa_px[COORD_W] | sa_pz[COORD_W];
			end
			default: begin
				pose_d = pose_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q    <= POSE_RESET;
			sat_out_q <= 1'b0;
		end else if (dp_cmd.apply) begin
			pose_q    <= pose_d;
			sat_out_q <= sat_acc_q | hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			op_q      <= op_t'(in_cmd);
			amt_q     <= in_amount;
			rem_q     <= REM_W'(in_amount) + MOD_BIAS;
			sat_acc_q <= 1'b0;
		end else if (dp_cmd.take_ox || dp_cmd.take_oz) begin
			sat_acc_q <= sat_acc_q | !acc_fits;
		end
		if (dp_cmd.mod_step) begin
			rem_q <= rem_2;
		end
		if (dp_cmd.fold) begin
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= z_fold;
			flip_q <= flip_d;
		end else if (dp_cmd.rot_step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_i;
			end
		end
		if (dp_cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		case (dp_cmd.acc_op)
			ACC_LOAD: acc_q <= prod_s1;
			ACC_ADD:  acc_q <= acc_q + prod_s1;
			ACC_SUB:  acc_q <= acc_q - prod_s1;
			default:  acc_q <= acc_q;
		endcase
		if (dp_cmd.take_ox) begin
			ox_q <= acc_clamp;
		end
		if (dp_cmd.take_oz) begin
			oz_q <= acc_clamp;
		end
	end

	assign pose       = pose_q;
	assign saturated  = sat_out_q;
	assign dp_stat.op = op_q;

endmodule

`default_nettype wire

// File: hw/rtl/campose_ctrl.sv
// campose_ctrl: sequencer for the pose datapath and the result valid flag
// depends on campose_pkg; issues dp_cmd_t to campose_dp
`timescale 1ns / 1ps
`default_nettype none

module campose_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [campose_pkg::OP_W-1:0] in_cmd,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output campose_pkg::dp_cmd_t         dp_cmd,
	input  campose_pkg::dp_stat_t        dp_stat
);
	import campose_pkg::*;

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic [CNT_W-1:0] prod_last;
	dp_cmd_t          dpc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		dpc       = '0;
		in_ready  = 1'b0;
		prod_last = CNT_W'(PROD_LAST_MOVE);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dpc.load = 1'b1;
					cnt_d    = '0;
					case (op_t'(in_cmd))
						OP_ROTATE:             state_d = ST_MOD;
						OP_FORWARD, OP_STRAFE: state_d = ST_PROD;
						default:               state_d = ST_APPLY;
					endcase
				end
			end
			ST_MOD: begin
				dpc.mod_step = 1'b1;
				dpc.idx      = IDX_W'(cnt_q);
				if (cnt_q == CNT_W'(MOD_PAIRS - 1)) begin
					cnt_d   = '0;
					state_d = ST_FOLD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FOLD: begin
				dpc.fold = 1'b1;
				cnt_d    = '0;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				dpc.rot_step = 1'b1;
				dpc.idx      = IDX_W'(cnt_q);
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_PROD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PROD: begin
				// multiplier product is registered and reaches the accumulator in the next cycle
				if (dp_stat.op == OP_ROTATE) begin
					prod_last = CNT_W'(PROD_LAST_ROT);
					case (cnt_q)
						CNT_W'(0): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_CS_DX;
						end
						CNT_W'(1): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_SN_DZ;
							dpc.acc_op  = ACC_LOAD;
						end
						CNT_W'(2): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_SN_DX;
							dpc.acc_op  = ACC_SUB;
						end
						CNT_W'(3): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_CS_DZ;
							dpc.acc_op  = ACC_LOAD;
							dpc.take_ox = 1'b1;
						end
						CNT_W'(4): begin
							dpc.acc_op = ACC_ADD;
						end
						default: begin
							dpc.take_oz = 1'b1;
						end
					endcase
				end else begin
					case (cnt_q)
						CNT_W'(0): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_DIRX_AMT;
						end
						CNT_W'(1): begin
							dpc.mul_en  = 1'b1;
							dpc.mul_sel = MS_DIRZ_AMT;
							dpc.acc_op  = ACC_LOAD;
						end
						CNT_W'(2): begin
							dpc.acc_op  = ACC_LOAD;
							dpc.take_ox = 1'b1;
						end
						default: begin
							dpc.take_oz = 1'b1;
						end
					endcase
				end
				if (cnt_q == prod_last) begin
					cnt_d   = '0;
					state_d = ST_APPLY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_APPLY: begin
				// pose registers double as the result register
				if (!out_valid_q || out_ready) begin
					dpc.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = (out_valid_q && !out_ready) || dpc.apply;
	end

	assign dp_cmd    = dpc;
	assign out_valid = out_valid_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start a command");

	a_apply_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		dpc.apply |-> (!out_valid_q || out_ready))
		else $error("pose updated while the previous result is pending");

	a_apply_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && out_valid_q && !out_ready) |=> (state_q == ST_APPLY))
		else $error("apply left while output is stalled");

	a_mod_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (cnt_q < CNT_W'(MOD_PAIRS)))
		else $error("angle reduction count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/camera_pose_update.sv
// camera_pose_update: reload, vertical and unused codes go straight to the pose update;
// forward and strafe first run the product phase; rotate first runs the modulo two pi
// reduction, the fold, one cordic step per cycle and then the product phase
// one command at a time, a beat is taken only in idle; the next beat is taken while a
// result still waits on the output, and the update stalls until that result is taken
// arst_n clears the sequencer, loads the start registers and the pose with their defaults
`timescale 1ns / 1ps
`default_nettype none

module camera_pose_update #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	campose_cmd_if.sink                         cmd_ch,
	campose_pose_if.source                      pose_ch,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [campose_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [campose_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [campose_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                pready
);
	import campose_pkg::*;

	// start pose registers, written through apb, only used on a reload command
	pose_t    cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= POSE_RESET;
		end else if (wr_en) begin
			// addresses past the last register are dropped
			case (reg_sel)
				REG_START_POS_X:  cfg_q.pos_x  <= pwdata;
				REG_START_POS_Y:  cfg_q.pos_y  <= pwdata;
				REG_START_POS_Z:  cfg_q.pos_z  <= pwdata;
				REG_START_VIEW_X: cfg_q.look_x <= pwdata;
				REG_START_VIEW_Y: cfg_q.look_y <= pwdata;
				REG_START_VIEW_Z: cfg_q.look_z <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_START_POS_X:  prdata = cfg_q.pos_x;
			REG_START_POS_Y:  prdata = cfg_q.pos_y;
			REG_START_POS_Z:  prdata = cfg_q.pos_z;
			REG_START_VIEW_X: prdata = cfg_q.look_x;
			REG_START_VIEW_Y: prdata = cfg_q.look_y;
			REG_START_VIEW_Z: prdata = cfg_q.look_z;
			default:          prdata = '0;
		endcase
	end

	// controller to datapath command and status
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	pose_t    pose;
	logic     saturated;

	campose_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_ch.valid),
		.in_cmd    (cmd_ch.cmd),
		.in_ready  (cmd_ch.ready),
		.out_valid (pose_ch.valid),
		.out_ready (pose_ch.ready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	// datapath: pose state, angle reduction, cordic, shared 34x34 multiplier
	campose_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.in_cmd    (cmd_ch.cmd),
		.in_amount (cmd_ch.amount),
		.cfg_pose  (cfg_q),
		.pose      (pose),
		.saturated (saturated)
	);

	// result beat comes straight off the pose registers, held until taken
	assign pose_ch.pos_x     = pose.pos_x;
	assign pose_ch.pos_y     = pose.pos_y;
	assign pose_ch.pos_z     = pose.pos_z;
	assign pose_ch.look_x    = pose.look_x;
	assign pose_ch.look_y    = pose.look_y;
	assign pose_ch.look_z    = pose.look_z;
	assign pose_ch.saturated = saturated;

endmodule

`default_nettype wire
